[rtl/irt_pkg.sv]
// Shared types, constants and the digit alphabet for the radix text converter.
`default_nettype none

package irt_pkg;

  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 7;
  localparam int BASE_W     = 7;
  localparam int BYTE_IDX_W = 3;

  localparam logic [BYTE_IDX_W-1:0] TOP_BYTE = 3'd7;
  localparam logic [VALUE_W-1:0]    MAX_MAG  = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [BASE_W-1:0] BASE_MIN = 7'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 7'd64;
  localparam logic [BASE_W-1:0] BASE_ALNUM = 7'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_UNDER = 7'h5F;  // '_'

  // Configuration register indexes
  localparam logic REG_RADIX = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_SIGN,
    ST_EMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic digit_end;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic last_byte;
    logic quo_zero;
    logic negative;
    logic ptr_zero;
  } sts_t;

  // Map a digit value to its ASCII character for the given base.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [5:0] d,
                                                   input logic [BASE_W-1:0] base,
                                                   input logic upper);
    logic [CHAR_W-1:0] dv;
    logic [CHAR_W-1:0] ch;
    dv = {1'b0, d};
    if (base >= BASE_MAX) begin
      // base64url: A-Z a-z 0-9 - _
      if (dv < 7'd26)      ch = CHAR_UPPER_A + dv;
      else if (dv < 7'd52) ch = CHAR_LOWER_A + (dv - 7'd26);
      else if (dv < 7'd62) ch = CHAR_ZERO + (dv - 7'd52);
      else if (dv == 7'd62) ch = CHAR_MINUS;
      else                 ch = CHAR_UNDER;
    end else if (base <= BASE_ALNUM && !upper) begin
      if (dv < 7'd10)      ch = CHAR_ZERO + dv;
      else if (dv < 7'd36) ch = CHAR_LOWER_A + (dv - 7'd10);
      else                 ch = CHAR_ZERO;
    end else begin
      if (dv < 7'd10)      ch = CHAR_ZERO + dv;
      else if (dv < 7'd36) ch = CHAR_UPPER_A + (dv - 7'd10);
      else if (dv < 7'd62) ch = CHAR_LOWER_A + (dv - 7'd36);
      else if (dv == 7'd62) ch = CHAR_MINUS;
      else                 ch = CHAR_ZERO;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

[rtl/irt_ctrl.sv]
// Controller state machine for the radix text converter.
`default_nettype none

module irt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire irt_pkg::sts_t sts,
  output irt_pkg::cmd_t      cmd
);

  irt_pkg::state_t state;
  irt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      irt_pkg::ST_IDLE: begin
        if (start) state_next = irt_pkg::ST_DIV;
      end
      irt_pkg::ST_DIV: begin
        if (sts.last_byte) state_next = irt_pkg::ST_DIGIT;
      end
      irt_pkg::ST_DIGIT: begin
        if (!sts.quo_zero)     state_next = irt_pkg::ST_DIV;
        else if (sts.negative) state_next = irt_pkg::ST_SIGN;
        else                   state_next = irt_pkg::ST_EMIT;
      end
      irt_pkg::ST_SIGN: begin
        state_next = irt_pkg::ST_EMIT;
      end
      irt_pkg::ST_EMIT: begin
        if (sts.ptr_zero) state_next = irt_pkg::ST_FINISH;
      end
      irt_pkg::ST_FINISH: begin
        state_next = irt_pkg::ST_IDLE;
      end
      default: begin
        state_next = irt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      irt_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      irt_pkg::ST_DIV:    cmd.div_step   = 1'b1;
      irt_pkg::ST_DIGIT:  cmd.digit_end  = 1'b1;
      irt_pkg::ST_SIGN:   cmd.emit_sign  = 1'b1;
      irt_pkg::ST_EMIT:   cmd.emit_digit = 1'b1;
      irt_pkg::ST_FINISH: cmd            = '0;
      default:            busy           = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/irt_datapath.sv]
// Datapath: config registers, byte-serial divider, digit buffer and output stage.
`default_nettype none

module irt_datapath #(
  parameter int MAX_DIGITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire irt_pkg::cmd_t         cmd,
  output irt_pkg::sts_t              sts,
  input  wire logic [63:0]           value,
  input  wire logic                  write_enable,
  input  wire logic                  reg_index,
  input  wire logic [6:0]            write_data,
  output logic                       char_valid,
  output logic [6:0]                 char_code,
  output logic [6:0]                 digit_count,
  output logic                       is_last
);

  localparam int AW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [irt_pkg::BASE_W-1:0] radix;
  logic                       upper_case;
  logic [irt_pkg::BASE_W-1:0] base;

  logic [63:0]                     quo;
  logic [63:0]                     quo_next;
  logic [6:0]                      rem;
  logic [6:0]                      rem_next;
  logic [7:0]                      byte_in;
  logic [7:0]                      qbyte;
  logic [7:0]                      trial;
  logic [irt_pkg::BYTE_IDX_W-1:0]  bidx;
  logic [irt_pkg::BYTE_IDX_W-1:0]  top;
  logic [irt_pkg::BYTE_IDX_W-1:0]  top_next;
  logic [7:0]                      top_byte;
  logic [63:0]                     mag;
  logic                            negative;

  logic [CW-1:0]               cnt;
  logic [AW-1:0]               ptr;
  logic [irt_pkg::CHAR_W-1:0]  mem [MAX_DIGITS];
  logic [irt_pkg::CHAR_W-1:0]  rd_data;
  logic [irt_pkg::CHAR_W-1:0]  dig_char;

  logic emit_sign_q;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= 7'd10;
      upper_case <= 1'b1;
    end else if (write_enable) begin
      case (reg_index)
        irt_pkg::REG_RADIX: radix      <= write_data;
        irt_pkg::REG_UPPER: upper_case <= write_data[0];
        default:            radix      <= radix;
      endcase
    end
  end

  always_comb begin
    if (radix < irt_pkg::BASE_MIN)      base = irt_pkg::BASE_MIN;
    else if (radix > irt_pkg::BASE_MAX) base = irt_pkg::BASE_MAX;
    else                                base = radix;
  end

  // Magnitude, saturating the most negative value
  always_comb begin
    mag = value[63] ? (~value + 64'd1) : value;
    if (mag[63]) mag = irt_pkg::MAX_MAG;
  end

  // One quotient byte per cycle: eight restoring steps on the narrow remainder
  always_comb begin
    byte_in  = quo[{bidx, 3'b000} +: 8];
    rem_next = rem;
    qbyte    = '0;
    trial    = '0;
    for (int i = 7; i >= 0; i--) begin
      trial = {rem_next, byte_in[i]};
      if (trial >= {1'b0, base}) begin
        rem_next = 7'(trial - {1'b0, base});
        qbyte[i] = 1'b1;
      end else begin
        rem_next = trial[6:0];
      end
    end
    quo_next = quo;
    quo_next[{bidx, 3'b000} +: 8] = qbyte;
  end

  // Drop the top byte once the quotient has shrunk below it
  always_comb begin
    top_byte = quo[{top, 3'b000} +: 8];
    if (top != '0 && top_byte == 8'd0) top_next = top - 1'b1;
    else                                top_next = top;
  end

  assign dig_char = irt_pkg::digit_char(rem[5:0], base, upper_case);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      top  <= irt_pkg::TOP_BYTE;
      bidx <= irt_pkg::TOP_BYTE;
    end else if (cmd.load) begin
      cnt  <= '0;
      top  <= irt_pkg::TOP_BYTE;
      bidx <= irt_pkg::TOP_BYTE;
    end else if (cmd.div_step) begin
      if (bidx != '0) bidx <= bidx - 1'b1;
    end else if (cmd.digit_end) begin
      top  <= top_next;
      bidx <= top_next;
      if (cnt < CW'(MAX_DIGITS)) cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo      <= mag;
      rem      <= '0;
      negative <= value[63];
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end else if (cmd.digit_end) begin
      rem <= '0;
    end
  end

  // Digit buffer: written least significant first, read back in reverse
  always_ff @(posedge clk) begin
    if (cmd.digit_end && cnt < CW'(MAX_DIGITS)) begin
      mem[cnt[AW-1:0]] <= dig_char;
    end
    if (cmd.emit_digit) begin
      rd_data <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.digit_end && cnt < CW'(MAX_DIGITS)) begin
      ptr <= cnt[AW-1:0];
    end else if (cmd.emit_digit) begin
      ptr <= ptr - 1'b1;
    end
  end

  // Output stage, aligned with the registered buffer read
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid  <= 1'b0;
      emit_sign_q <= 1'b0;
      is_last     <= 1'b0;
    end else begin
      char_valid  <= cmd.emit_sign | cmd.emit_digit;
      emit_sign_q <= cmd.emit_sign;
      is_last     <= cmd.emit_digit && ptr == '0;
    end
  end

  assign char_code   = emit_sign_q ? irt_pkg::CHAR_MINUS : rd_data;
  assign digit_count = 7'(cnt);

  assign sts.last_byte = (bidx == '0);
  assign sts.quo_zero  = (quo == '0);
  assign sts.negative  = negative;
  assign sts.ptr_zero  = (ptr == '0);

endmodule

`default_nettype wire

[rtl/integer_to_radix_text.sv]
// Top level of the signed integer to radix text converter.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  input     | start, busy               | value[63:0] (signed)
//  result    | char_valid (one cycle)    | char_code[6:0], digit_count[6:0],
//            |                           | is_last
//  config    | write_enable, reg_index   | write_data[6:0]
//
//  A word is taken when start is high and busy is low. For each digit the
//  divider scans the quotient bytes still in use, top byte down: 8 for the first
//  digit, one fewer after each digit that leaves the top byte empty, never
//  below 1. The divider retires one quotient byte per cycle against the base.
//  Emission then gives the sign, for a negative value, and then the digits,
//  most significant first.
//  Synchronous active-high reset returns radix to 10 and upper_case to 1.
//  Result words are not held back: each is shown for exactly one cycle and
//  the receiver must take it then.
`default_nettype none

module integer_to_radix_text #(
  parameter int MAX_DIGITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] value,
  input  wire logic        write_enable,
  input  wire logic        reg_index,
  input  wire logic [6:0]  write_data,
  output logic             char_valid,
  output logic [6:0]       char_code,
  output logic [6:0]       digit_count,
  output logic             is_last
);

  irt_pkg::cmd_t cmd;
  irt_pkg::sts_t sts;

  // Sequence the division loop, the sign and the reversed read-out
  irt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Hold config, divide, buffer digits and drive the result word
  irt_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .char_valid   (char_valid),
    .char_code    (char_code),
    .digit_count  (digit_count),
    .is_last      (is_last)
  );

endmodule

`default_nettype wire

[rtl/irt_checker.sv]
// Port-level checks for the radix text converter, bound to the top level.
`default_nettype none

module irt_checker #(
  parameter int MAX_DIGITS = 64
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       char_valid,
  input wire logic [6:0] digit_count,
  input wire logic       is_last
);

  // A taken word raises busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after start");

  // Results only appear while a word is in progress
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> busy) else $error("result outside busy window");

  // Characters of one word come back to back and stop after the last
  a_burst: assert property (@(posedge clk) disable iff (rst)
    char_valid && !is_last |=> char_valid) else $error("gap inside a word");

  a_last_end: assert property (@(posedge clk) disable iff (rst)
    char_valid && is_last |=> !char_valid) else $error("result after last");

  a_count: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> digit_count != 7'd0 && digit_count <= 7'(MAX_DIGITS))
    else $error("digit count out of range");

endmodule

bind integer_to_radix_text irt_checker #(.MAX_DIGITS(MAX_DIGITS)) u_irt_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .char_valid  (char_valid),
  .digit_count (digit_count),
  .is_last     (is_last)
);

`default_nettype wire
